[design/assert_macros.svh]
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define ITCMA_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// expression must never be true outside reset
`define ITCMA_NEVER(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define ITCMA_ASSERT(lbl, clk, rst, prop, msg)
`define ITCMA_NEVER(lbl, clk, rst, expr, msg)

`endif

`endif

[design/itcma_pkg.sv]
// shared types and constants of the two-channel moving average unit
package itcma_pkg;

  // fixed field widths
  localparam int RAW_W  = 10;
  localparam int MV_W   = 12;
  localparam int TEMP_W = 10;

  // millivolt scaling and fahrenheit conversion constants
  localparam int MV_FULL_SCALE = 3000;
  localparam int TEMP_GAIN     = 9;
  localparam int TEMP_OFFSET   = 2900;
  localparam int TEMP_DIV      = 50;
  localparam int TEMP_RESET    = -58;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SUM,
    S_DIVL,
    S_WAITL,
    S_TNUM,
    S_DIVT,
    S_WAITT,
    S_DONE
  } state_t;

  // divider status seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

[design/itcma_ring.sv]
// sample ring memory for both channels, one write and one registered read port
module itcma_ring #(
  parameter int WINDOW = 10
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [$clog2(2*WINDOW)-1:0]           waddr,
  input  logic [itcma_pkg::MV_W-1:0]            wdata,
  input  logic [$clog2(2*WINDOW)-1:0]           raddr,
  output logic [itcma_pkg::MV_W-1:0]            rdata
);
  import itcma_pkg::*;

  localparam int DEPTH = 2 * WINDOW;

  logic [MV_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[design/itcma_div.sv]
// shared restoring divider, one quotient bit per cycle
module itcma_div #(
  parameter int DVD_W = 24,
  parameter int DVS_W = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DVD_W-1:0]      dividend,
  input  logic [DVS_W-1:0]      divisor,
  output logic [DVD_W-1:0]      quotient,
  output itcma_pkg::div_stat_t  stat
);
  import itcma_pkg::*;

  localparam int CW = $clog2(DVD_W + 1);

  logic             busy;
  logic             done;
  logic [CW-1:0]    cnt;
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [DVD_W-1:0] dq;

  logic [DVS_W:0]   rem_sh;
  logic [DVS_W:0]   diff;
  logic             ge;

  // one trial subtraction per step
  always_comb begin
    rem_sh = {rem, dq[DVD_W-1]};
    diff   = rem_sh - {1'b0, dvs};
    ge     = !diff[DVS_W];
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= CW'(DVD_W);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      dq  <= dividend;
      dvs <= divisor;
      rem <= '0;
    end else if (busy) begin
      rem <= ge ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
      dq  <= {dq[DVD_W-2:0], ge};
    end
  end

  assign quotient  = dq;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

[design/interleaved_two_channel_moving_average_unit.sv]
// top level: interleaved light and temperature moving average with shared divider
//
//  channel  handshake               payload
//  in       in_valid / in_ready     raw_sample
//  out      out_valid / out_ready   light_level_mv, temperature_f
//
// a light beat goes from S_IDLE straight to S_DONE, which loads the output
// register as soon as it is free and returns to S_IDLE. a temperature beat
// first walks the ring in S_SUM, reading both channels' samples through its
// single read port, then the bit-serial divider (NUM_W = 21 at WINDOW = 10)
// forms the light mean in S_DIVL and S_WAITL, S_TNUM builds the temperature
// numerator, and the divider forms the temperature in S_DIVT and S_WAITT.
// in_ready is high only while the sequencer is idle; one result may wait in
// the output register while the next beat is taken. reset clears control
// state and the averages; the ring is not cleared and needs no clearing pass.
`include "assert_macros.svh"

module interleaved_two_channel_moving_average_unit #(
  parameter int WINDOW      = 10,
  parameter int SAMPLE_BITS = 10
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [itcma_pkg::RAW_W-1:0]         raw_sample,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [itcma_pkg::MV_W-1:0]          light_level_mv,
  output logic signed [itcma_pkg::TEMP_W-1:0] temperature_f
);
  import itcma_pkg::*;

  localparam int AW     = $clog2(2 * WINDOW);
  localparam int SW     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int KW     = CNT_W + 1;
  localparam int SUM_W  = MV_W + CNT_W;
  localparam int NUM_W  = SUM_W + 5;
  localparam int DVS_W  = CNT_W + 6;
  localparam int PROD_W = RAW_W + MV_W;
  localparam logic [RAW_W-1:0] RAW_MASK =
    (SAMPLE_BITS >= RAW_W) ? {RAW_W{1'b1}} : RAW_W'((32'd1 << SAMPLE_BITS) - 32'd1);

  state_t state;
  state_t state_next;

  logic             channel_turn;
  logic [SW-1:0]    slot;
  logic             wrapped;
  logic [CNT_W-1:0] count;
  logic [KW-1:0]    k;
  logic             rd_pend;
  logic             rd_temp;
  logic [SUM_W-1:0] light_sum;
  logic [SUM_W-1:0] temp_sum;
  logic             num_neg;
  logic [NUM_W-1:0] num_mag;
  logic [DVS_W-1:0] den;
  logic [MV_W-1:0]  light_mean;
  logic signed [TEMP_W-1:0] temp_f;

  logic             accept;
  logic             rd_issue;
  logic             div_start;
  logic             load_out;
  logic [PROD_W-1:0] prod;
  logic [MV_W-1:0]  mv;
  logic [SW-1:0]    slot_inc;
  logic             wrap_now;
  logic [AW-1:0]    waddr;
  logic [AW-1:0]    raddr;
  logic [MV_W-1:0]  rdata;
  logic signed [NUM_W-1:0] num_c;
  logic [NUM_W-1:0] div_dvd;
  logic [DVS_W-1:0] div_dvs;
  logic [NUM_W-1:0] quot;
  div_stat_t        div_stat;

  // millivolt scaling of the incoming beat
  always_comb begin
    prod = PROD_W'(raw_sample & RAW_MASK) * PROD_W'(MV_FULL_SCALE);
    mv   = MV_W'(prod >> SAMPLE_BITS);
  end

  // slot advance and ring addresses
  always_comb begin
    wrap_now = (slot == SW'(WINDOW - 1));
    slot_inc = wrap_now ? '0 : slot + SW'(1);
    waddr    = channel_turn ? AW'(WINDOW) + AW'(slot) : AW'(slot);
    raddr    = (k < KW'(count)) ? AW'(k) : AW'(WINDOW) + AW'(k - KW'(count));
  end

  // temperature numerator before division
  always_comb begin
    num_c = $signed(NUM_W'(temp_sum) * NUM_W'(TEMP_GAIN))
          - $signed(NUM_W'(count) * NUM_W'(TEMP_OFFSET));
  end

  // divider operand select
  always_comb begin
    div_dvd = (state == S_DIVL) ? NUM_W'(light_sum) : num_mag;
    div_dvs = (state == S_DIVL) ? DVS_W'(count) : den;
  end

  itcma_ring #(
    .WINDOW(WINDOW)
  ) u_ring (
    .clk  (clk),
    .we   (accept),
    .waddr(waddr),
    .wdata(mv),
    .raddr(raddr),
    .rdata(rdata)
  );

  itcma_div #(
    .DVD_W(NUM_W),
    .DVS_W(DVS_W)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(div_dvd),
    .divisor (div_dvs),
    .quotient(quot),
    .stat    (div_stat)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and sequencer outputs
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    rd_issue   = 1'b0;
    div_start  = 1'b0;
    load_out   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = channel_turn ? S_SUM : S_DONE;
        end
      end
      S_SUM: begin
        rd_issue = (k < {count, 1'b0});
        if (!rd_issue && !rd_pend) begin
          state_next = S_DIVL;
        end
      end
      S_DIVL: begin
        div_start  = 1'b1;
        state_next = S_WAITL;
      end
      S_WAITL: begin
        if (div_stat.done) begin
          state_next = S_TNUM;
        end
      end
      S_TNUM: begin
        state_next = S_DIVT;
      end
      S_DIVT: begin
        div_start  = 1'b1;
        state_next = S_WAITT;
      end
      S_WAITT: begin
        if (div_stat.done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign accept = in_valid && in_ready;

  // channel, slot and averages
  always_ff @(posedge clk) begin
    if (rst) begin
      channel_turn <= 1'b0;
      slot         <= '0;
      wrapped      <= 1'b0;
      count        <= '0;
      light_mean   <= '0;
      temp_f       <= TEMP_W'(TEMP_RESET);
    end else begin
      if (accept) begin
        channel_turn <= !channel_turn;
        if (channel_turn) begin
          slot <= slot_inc;
          if (wrap_now) begin
            wrapped <= 1'b1;
          end
          count <= (wrap_now || wrapped) ? CNT_W'(WINDOW) : CNT_W'(slot_inc);
        end
      end
      if (state == S_WAITL && div_stat.done) begin
        light_mean <= quot[MV_W-1:0];
      end
      if (state == S_WAITT && div_stat.done) begin
        temp_f <= num_neg ? -$signed(quot[TEMP_W-1:0]) : $signed(quot[TEMP_W-1:0]);
      end
    end
  end

  // ring walk and accumulation
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= rd_issue;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      k         <= '0;
      light_sum <= '0;
      temp_sum  <= '0;
    end else begin
      if (rd_issue) begin
        k       <= k + KW'(1);
        rd_temp <= (k >= KW'(count));
      end
      if (rd_pend) begin
        if (rd_temp) begin
          temp_sum <= temp_sum + SUM_W'(rdata);
        end else begin
          light_sum <= light_sum + SUM_W'(rdata);
        end
      end
    end
  end

  // numerator magnitude and denominator for the temperature division
  always_ff @(posedge clk) begin
    if (state == S_TNUM) begin
      num_neg <= num_c[NUM_W-1];
      num_mag <= num_c[NUM_W-1] ? NUM_W'(-num_c) : NUM_W'(num_c);
      den     <= DVS_W'(count) * DVS_W'(TEMP_DIV);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      light_level_mv <= light_mean;
      temperature_f  <= temp_f;
    end
  end

  // checks
  `ITCMA_NEVER(a_div_restart, clk, rst, div_start && div_stat.busy, "divider started while busy")
  `ITCMA_ASSERT(a_done_in_wait, clk, rst, div_stat.done |-> (state == S_WAITL || state == S_WAITT), "divider done outside a wait state")
  `ITCMA_ASSERT(a_light_direct, clk, rst, (accept && !channel_turn) |=> (state == S_DONE), "light beat not sent straight to result")
  `ITCMA_ASSERT(a_count_range, clk, rst, (state == S_SUM) |-> (count != '0 && count <= CNT_W'(WINDOW)), "average count out of range")

endmodule
